// ===== sv/audio_channel_router_delay_top_assert.svh =====
// Assertion macros for the audio channel router port checks
`ifndef AUDIO_CHANNEL_ROUTER_DELAY_TOP_ASSERT_SVH
`define AUDIO_CHANNEL_ROUTER_DELAY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ACRD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acrd same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ACRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acrd next-cycle check failed");

`endif

// ===== sv/acrd_pkg.sv =====
// Shared constants, types and helpers for the audio channel router
`timescale 1ns / 1ps

package acrd_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int DELAY_DEPTH  = 4096;
  localparam int SAMPLE_BITS  = 24;

  localparam int LANE_IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int POS_W        = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int LEN_W        = $clog2(DELAY_DEPTH + 1);

  localparam int COUNT_W      = 4;
  localparam int GAIN_W       = 16;
  localparam int DLY_FIELD_W  = 13;
  localparam int MAP_WORD_W   = 32;
  localparam int MAP_W        = 4;
  localparam int MAP_ENTRIES  = 8;
  localparam int FRAC_BITS    = 12;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam int MAG_W        = SAMPLE_BITS;
  localparam int PROD_W       = MAG_W + GAIN_W;
  localparam int RND_W        = PROD_W - FRAC_BITS;

  localparam logic [MAP_W-1:0]  SILENT_ENTRY = MAP_W'(15);
  localparam logic [GAIN_W-1:0] GAIN_UNITY   = GAIN_W'(4096);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MUTE     = 3'd0,
    REG_GAIN     = 3'd1,
    REG_DELAY    = 3'd2,
    REG_OVERRIDE = 3'd3,
    REG_MAP_LEN  = 3'd4,
    REG_MAP_WORD = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                   mute;
    logic [GAIN_W-1:0]      gain;
    logic [DLY_FIELD_W-1:0] delay_frames;
    logic [COUNT_W-1:0]     channel_override;
    logic [COUNT_W-1:0]     map_length;
    logic [MAP_WORD_W-1:0]  map_word;
  } cfg_regs_t;

  // Per-frame control that travels down the pipeline beside the lanes
  typedef struct packed {
    logic               delay_on;
    logic               filled;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] dest;
  } item_ctrl_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    clamp_count = (v > COUNT_W'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS) : v;
  endfunction

endpackage

// ===== sv/acrd_front.sv =====
// Frame front end: destination count, per-lane source routing and delay position
`timescale 1ns / 1ps

module acrd_front
  import acrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_regs_t          cfg,
  input  logic               cfg_clear,
  input  logic               take,
  input  sample_t            samples_i [MAX_CHANNELS],
  input  logic [COUNT_W-1:0] src_count_i,
  output sample_t            lane_sample_o [MAX_CHANNELS],
  output logic               lane_used_o [MAX_CHANNELS],
  output item_ctrl_t         ctrl_o
);

  logic [COUNT_W-1:0] last_dest_r, last_dest_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               filled_r, filled_nxt;

  logic [COUNT_W-1:0] src_cnt, mlen, dest;
  logic [LEN_W-1:0]   len;
  logic               clear, delay_on, wrap;
  logic [POS_W-1:0]   pos_cur, pos_adv;
  logic               filled_cur;

  // Destination count and effective delay length
  always_comb begin
    src_cnt = clamp_count(src_count_i);
    mlen    = clamp_count(cfg.map_length);
    if (cfg.channel_override != '0) begin
      dest = clamp_count(cfg.channel_override);
    end else if (mlen != '0) begin
      dest = mlen;
    end else begin
      dest = src_cnt;
    end
    if (int'(cfg.delay_frames) > DELAY_DEPTH) begin
      len = LEN_W'(DELAY_DEPTH);
    end else begin
      len = LEN_W'(cfg.delay_frames);
    end
  end

  // Position for this frame; a count change restarts the delay line empty
  always_comb begin
    clear    = (dest != last_dest_r);
    delay_on = (len != '0);
    if (clear || (LEN_W'(pos_r) >= len)) begin
      pos_cur = '0;
    end else begin
      pos_cur = pos_r;
    end
    filled_cur = clear ? 1'b0 : filled_r;
    wrap       = ((LEN_W'(pos_cur) + LEN_W'(1)) == len);
    pos_adv    = wrap ? '0 : (pos_cur + POS_W'(1));
  end

  // Next state of the delay bookkeeping
  always_comb begin
    last_dest_nxt = last_dest_r;
    pos_nxt       = pos_r;
    filled_nxt    = filled_r;
    if (cfg_clear) begin
      last_dest_nxt = '0;
      pos_nxt       = '0;
      filled_nxt    = 1'b0;
    end else if (take) begin
      last_dest_nxt = dest;
      if (delay_on) begin
        pos_nxt    = pos_adv;
        filled_nxt = filled_cur | wrap;
      end else if (clear) begin
        pos_nxt    = '0;
        filled_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dest_r <= '0;
      pos_r       <= '0;
      filled_r    <= 1'b0;
    end else begin
      last_dest_r <= last_dest_nxt;
      pos_r       <= pos_nxt;
      filled_r    <= filled_nxt;
    end
  end

  assign ctrl_o = '{delay_on: delay_on, filled: filled_cur, pos: pos_cur, dest: dest};

  // Per-lane source pick and silence
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_route
    logic [MAP_W-1:0] source;
    logic             used, silent;

    always_comb begin
      used   = (COUNT_W'(c) < dest);
      source = MAP_W'(c);
      if (mlen != '0) begin
        source = SILENT_ENTRY;
        if (c < MAP_ENTRIES) begin
          if (COUNT_W'(c) < mlen) begin
            source = cfg.map_word[MAP_W*(c % MAP_ENTRIES) +: MAP_W];
          end
        end
      end
      silent = cfg.mute || (source == SILENT_ENTRY) || (COUNT_W'(source) >= src_cnt);
      if (used && !silent) begin
        lane_sample_o[c] = samples_i[source[LANE_IDX_W-1:0]];
      end else begin
        lane_sample_o[c] = '0;
      end
      lane_used_o[c] = used;
    end
  end

endmodule

// ===== sv/acrd_lane.sv =====
// One destination lane: gain multiply, round/saturate and delay RAM
`timescale 1ns / 1ps

module acrd_lane
  import acrd_pkg::*;
(
  input  logic              clk,
  input  logic              ld1,
  input  logic              ld2,
  input  logic              ldo,
  input  sample_t           sample_i,
  input  logic              used_i,
  input  logic [GAIN_W-1:0] gain_i,
  input  item_ctrl_t        ctrl2_i,
  input  item_ctrl_t        ctrlo_i,
  output sample_t           sample_o
);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [RND_W-1:0]  POS_LIM    = RND_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic [RND_W-1:0]  NEG_LIM    = RND_W'(longint'(1) << (SAMPLE_BITS - 1));
  localparam sample_t           SAT_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t           SAT_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Stage 1: routed sample
  sample_t             s1_sample_r;
  logic                s1_used_r;
  // Stage 2: product magnitude
  logic [PROD_W-1:0]   s2_prod_r;
  logic                s2_neg_r;
  logic                s2_used_r;
  // Output stage
  sample_t             o_scaled_r;
  logic [SAMPLE_BITS-1:0] o_rdata_r;
  logic                o_used_r;

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic                s1_neg;
  logic [MAG_W-1:0]    s1_raw, s1_mag;
  logic [PROD_W-1:0]   prod_nxt, rsum;
  logic [RND_W-1:0]    rnd;
  sample_t             scaled;

  // Magnitude and product
  always_comb begin
    s1_neg   = s1_sample_r[SAMPLE_BITS-1];
    s1_raw   = MAG_W'(s1_sample_r);
    s1_mag   = s1_neg ? (~s1_raw + MAG_W'(1)) : s1_raw;
    prod_nxt = s1_mag * gain_i;
  end

  // Round half away from zero, then saturate
  always_comb begin
    rsum = s2_prod_r + ROUND_HALF;
    rnd  = rsum[PROD_W-1:FRAC_BITS];
    if (!s2_neg_r) begin
      scaled = (rnd > POS_LIM) ? SAT_MAX : sample_t'(rnd[SAMPLE_BITS-1:0]);
    end else begin
      scaled = (rnd > NEG_LIM) ? SAT_MIN : sample_t'(~rnd[SAMPLE_BITS-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_sample_r <= sample_i;
      s1_used_r   <= used_i;
    end
    if (ld2) begin
      s2_prod_r <= prod_nxt;
      s2_neg_r  <= s1_neg;
      s2_used_r <= s1_used_r;
    end
    if (ldo) begin
      o_scaled_r <= scaled;
      o_used_r   <= s2_used_r;
    end
  end

  // Delay RAM: old entry is read and new sample written at the same edge
  always_ff @(posedge clk) begin
    if (ldo) begin
      o_rdata_r <= mem[ctrl2_i.pos];
      if (ctrl2_i.delay_on && s2_used_r) begin
        mem[ctrl2_i.pos] <= scaled;
      end
    end
  end

  // Entries not yet written since the last restart read as zero
  always_comb begin
    if (!o_used_r) begin
      sample_o = '0;
    end else if (!ctrlo_i.delay_on) begin
      sample_o = o_scaled_r;
    end else if (ctrlo_i.filled) begin
      sample_o = sample_t'(o_rdata_r);
    end else begin
      sample_o = '0;
    end
  end

endmodule

// ===== sv/audio_channel_router_delay_top.sv =====
// Top level of the audio channel router with gain and delay
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  in      | in_valid / in_ready       | in_source_sample_0..7, in_source_count
//  out     | out_valid / out_ready     | out_sample_0..7, out_count
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One frame per cycle sustained while out_ready does not stall the result.
//  Stages: route, multiply, round/saturate plus delay RAM access; each lane's
//  RAM does one read per frame and, for a used lane with delay on, one write at the same edge.
//  rst_n is synchronous; the delay store needs no clearing pass: a fill flag
//  and the shared position make unwritten entries read as zero.
//  A stalled result holds its stage; the pipeline keeps filling behind it.
`timescale 1ns / 1ps

module audio_channel_router_delay_top
  import acrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_0,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_1,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_2,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_3,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_4,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_5,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_6,
  input  logic [SAMPLE_BITS-1:0] in_source_sample_7,
  input  logic [COUNT_W-1:0]    in_source_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample_0,
  output logic [SAMPLE_BITS-1:0] out_sample_1,
  output logic [SAMPLE_BITS-1:0] out_sample_2,
  output logic [SAMPLE_BITS-1:0] out_sample_3,
  output logic [SAMPLE_BITS-1:0] out_sample_4,
  output logic [SAMPLE_BITS-1:0] out_sample_5,
  output logic [SAMPLE_BITS-1:0] out_sample_6,
  output logic [SAMPLE_BITS-1:0] out_sample_7,
  output logic [COUNT_W-1:0]    out_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       cfg_we, cfg_clear;

  logic       v1_r, v1_nxt, v2_r, v2_nxt, vo_r, vo_nxt;
  logic       mv_1, mv_o, take;
  item_ctrl_t ctrl, ctrl1_r, ctrl2_r, ctrlo_r;

  sample_t    samples [MAX_CHANNELS];
  sample_t    lane_sample [MAX_CHANNELS];
  logic       lane_used [MAX_CHANNELS];
  sample_t    lane_out [MAX_CHANNELS];

  // Configuration registers; any known index restarts the delay line
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_we) begin
      cfg_clear = 1'b1;
      case (cfg_index)
        REG_MUTE:     cfg_nxt.mute             = cfg_data[0];
        REG_GAIN:     cfg_nxt.gain             = cfg_data[GAIN_W-1:0];
        REG_DELAY:    cfg_nxt.delay_frames     = cfg_data[DLY_FIELD_W-1:0];
        REG_OVERRIDE: cfg_nxt.channel_override = cfg_data[COUNT_W-1:0];
        REG_MAP_LEN:  cfg_nxt.map_length       = cfg_data[COUNT_W-1:0];
        REG_MAP_WORD: cfg_nxt.map_word         = cfg_data[MAP_WORD_W-1:0];
        default:      cfg_clear                = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mute: 1'b0, gain: GAIN_UNITY, delay_frames: '0,
                 channel_override: '0, map_length: '0, map_word: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline valid chain
  always_comb begin
    mv_o     = v2_r & (~vo_r | out_ready);
    mv_1     = v1_r & (~v2_r | mv_o);
    in_ready = ~v1_r | mv_1;
    take     = in_valid & in_ready;
    v1_nxt   = take | (v1_r & ~mv_1);
    v2_nxt   = mv_1 | (v2_r & ~mv_o);
    vo_nxt   = mv_o | (vo_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  // Frame control follows the lanes stage by stage
  always_ff @(posedge clk) begin
    if (take) ctrl1_r <= ctrl;
    if (mv_1) ctrl2_r <= ctrl1_r;
    if (mv_o) ctrlo_r <= ctrl2_r;
  end

  assign samples[0] = sample_t'(in_source_sample_0);
  assign samples[1] = sample_t'(in_source_sample_1);
  assign samples[2] = sample_t'(in_source_sample_2);
  assign samples[3] = sample_t'(in_source_sample_3);
  assign samples[4] = sample_t'(in_source_sample_4);
  assign samples[5] = sample_t'(in_source_sample_5);
  assign samples[6] = sample_t'(in_source_sample_6);
  assign samples[7] = sample_t'(in_source_sample_7);

  acrd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .cfg_clear     (cfg_clear),
    .take          (take),
    .samples_i     (samples),
    .src_count_i   (in_source_count),
    .lane_sample_o (lane_sample),
    .lane_used_o   (lane_used),
    .ctrl_o        (ctrl)
  );

  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
    acrd_lane u_lane (
      .clk      (clk),
      .ld1      (take),
      .ld2      (mv_1),
      .ldo      (mv_o),
      .sample_i (lane_sample[c]),
      .used_i   (lane_used[c]),
      .gain_i   (cfg_r.gain),
      .ctrl2_i  (ctrl2_r),
      .ctrlo_i  (ctrlo_r),
      .sample_o (lane_out[c])
    );
  end

  // Merge lanes into the result frame
  assign out_valid    = vo_r;
  assign out_count    = ctrlo_r.dest;
  assign out_sample_0 = lane_out[0];
  assign out_sample_1 = lane_out[1];
  assign out_sample_2 = lane_out[2];
  assign out_sample_3 = lane_out[3];
  assign out_sample_4 = lane_out[4];
  assign out_sample_5 = lane_out[5];
  assign out_sample_6 = lane_out[6];
  assign out_sample_7 = lane_out[7];

endmodule

// ===== sv/acrd_props.sv =====
// Port-level checks for the audio channel router, bound to the top level
`timescale 1ns / 1ps
`include "audio_channel_router_delay_top_assert.svh"

module acrd_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_sample_0,
  input logic [23:0] out_sample_7,
  input logic [3:0]  out_count,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // A stalled result holds
  `ACRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_0) && $stable(out_count))

  // Count never exceeds the lane count
  `ACRD_ASSERT_SAME(a_count_range, out_valid, out_count <= 4'd8)

  // Lane 7 is zero when the count leaves it out
  `ACRD_ASSERT_SAME(a_unused_lane_zero, out_valid && out_count <= 4'd7, out_sample_7 == 24'd0)

  // With no result waiting the pipeline always takes a request
  `ACRD_ASSERT_SAME(a_ready_when_drained, !out_valid, in_ready)

  // Configuration writes are never back-pressured
  `ACRD_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind audio_channel_router_delay_top acrd_props u_props (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the audio channel router with gain and delay
`timescale 1ns / 1ps

module testbench
  import acrd_pkg::*;
;

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] lanes_t;

  typedef struct packed {
    lanes_t             lanes;
    logic [COUNT_W-1:0] count;
  } frame_t;

  // Index past the register list: a write there must leave everything alone
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;

  localparam lanes_t MIXED_FRAME = {24'h000001, 24'hFFFFFF, 24'h000000, 24'h800000,
                                    24'h7FFFFF, 24'h000003, 24'hFFFFFD, 24'h000800};

  // Predicts routed frames and checks them in order
  class frame_scoreboard;
    logic                   mute_on;
    logic [GAIN_W-1:0]      gain_q;
    logic [DLY_FIELD_W-1:0] delay_len;
    logic [COUNT_W-1:0]     override;
    logic [COUNT_W-1:0]     map_len;
    logic [MAP_WORD_W-1:0]  map_word;

    // Delay lines; entries at or past `filled` have not been written since the last clear
    logic [SAMPLE_BITS-1:0] delay_line [MAX_CHANNELS][DELAY_DEPTH];
    int unsigned            position;
    int unsigned            filled;
    int unsigned            last_dest;

    frame_t      expected_frames[$];
    int unsigned failures;

    function new();
      mute_on   = 1'b0;
      gain_q    = GAIN_UNITY;
      delay_len = '0;
      override  = '0;
      map_len   = '0;
      map_word  = '0;
      position  = 0;
      filled    = 0;
      last_dest = 0;
      failures  = 0;
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    // Q4.12 gain, halves rounded away from zero, saturated to the sample range
    function logic [SAMPLE_BITS-1:0] apply_gain(input logic [SAMPLE_BITS-1:0] raw);
      longint s, mag, r, hi, lo;
      s   = longint'($signed(raw));
      mag = (s < 0) ? -s : s;
      r   = (mag * longint'(gain_q) + 2048) >>> FRAC_BITS;
      if (s < 0) r = -r;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      lo = -hi - 1;
      if (r > hi) r = hi;
      else if (r < lo) r = lo;
      return r[SAMPLE_BITS-1:0];
    endfunction

    // Any write to a known register clears the delay state
    function void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MUTE:     mute_on   = data[0];
        REG_GAIN:     gain_q    = data[GAIN_W-1:0];
        REG_DELAY:    delay_len = data[DLY_FIELD_W-1:0];
        REG_OVERRIDE: override  = data[COUNT_W-1:0];
        REG_MAP_LEN:  map_len   = data[COUNT_W-1:0];
        REG_MAP_WORD: map_word  = data[MAP_WORD_W-1:0];
        default: return;
      endcase
      position  = 0;
      filled    = 0;
      last_dest = 0;
    endfunction

    // Work out the routed frame for one accepted request
    function void note_frame(input lanes_t src, input logic [COUNT_W-1:0] src_cnt);
      int unsigned n_src, n_map, dest, len, source, pos;
      logic [SAMPLE_BITS-1:0] held;
      frame_t want;
      n_src = (src_cnt > MAX_CHANNELS) ? MAX_CHANNELS : src_cnt;
      n_map = (map_len > MAX_CHANNELS) ? MAX_CHANNELS : map_len;
      len   = (delay_len > DELAY_DEPTH) ? DELAY_DEPTH : delay_len;
      if (override != 0) dest = (override > MAX_CHANNELS) ? MAX_CHANNELS : override;
      else if (n_map != 0) dest = n_map;
      else dest = n_src;

      // new destination count starts the delay over
      if (dest != last_dest) begin
        position  = 0;
        filled    = 0;
        last_dest = dest;
      end

      want = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (c < dest) begin
          source = c;
          if (n_map != 0) source = (c < n_map) ? map_word[4*c +: MAP_W] : SILENT_ENTRY;
          if (!mute_on && source != SILENT_ENTRY && source < n_src)
            want.lanes[c] = apply_gain(src[source]);
        end
      end

      // shared-position delay: read the old sample, store the new one
      if (len != 0) begin
        pos = position;
        for (int c = 0; c < dest; c++) begin
          held = (pos < filled) ? delay_line[c][pos] : '0;
          delay_line[c][pos] = want.lanes[c];
          want.lanes[c] = held;
        end
        if (filled < len) filled++;
        position = (pos + 1 == len) ? 0 : pos + 1;
      end

      want.count = COUNT_W'(dest);
      expected_frames.insert(expected_frames.size(), want);
    endfunction

    function void check_frame(input lanes_t got, input logic [COUNT_W-1:0] got_count);
      frame_t want;
      if (expected_frames.size() == 0) begin
        $error("result frame with no request outstanding: out_count %0d", got_count);
        failures++;
        return;
      end
      want = expected_frames.pop_front();
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (got[c] !== want.lanes[c]) begin
          $error("out_sample_%0d: expected %0d, actual %0d", c,
                 $signed(want.lanes[c]), $signed(got[c]));
          failures++;
        end
      end
      if (got_count !== want.count) begin
        $error("out_count: expected %0d, actual %0d", want.count, got_count);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] in_source_sample_0 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_1 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_2 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_3 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_4 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_5 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_6 = '0;
  logic [SAMPLE_BITS-1:0] in_source_sample_7 = '0;
  logic [COUNT_W-1:0]     in_source_count = '0;

  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] out_sample_0, out_sample_1, out_sample_2, out_sample_3;
  logic [SAMPLE_BITS-1:0] out_sample_4, out_sample_5, out_sample_6, out_sample_7;
  logic [COUNT_W-1:0]     out_count;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  frame_scoreboard sb;
  int              quiet_cycles = 0;
  int              ready_hold = 0;
  int              ready_roll;

  always #1 clk = ~clk;

  audio_channel_router_delay_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_source_sample_0 (in_source_sample_0),
    .in_source_sample_1 (in_source_sample_1),
    .in_source_sample_2 (in_source_sample_2),
    .in_source_sample_3 (in_source_sample_3),
    .in_source_sample_4 (in_source_sample_4),
    .in_source_sample_5 (in_source_sample_5),
    .in_source_sample_6 (in_source_sample_6),
    .in_source_sample_7 (in_source_sample_7),
    .in_source_count    (in_source_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_0       (out_sample_0),
    .out_sample_1       (out_sample_1),
    .out_sample_2       (out_sample_2),
    .out_sample_3       (out_sample_3),
    .out_sample_4       (out_sample_4),
    .out_sample_5       (out_sample_5),
    .out_sample_6       (out_sample_6),
    .out_sample_7       (out_sample_7),
    .out_count          (out_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Monitor: config writes, results, then requests, all sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.apply_write(cfg_index, cfg_data);
      if (out_valid && out_ready)
        sb.check_frame({out_sample_7, out_sample_6, out_sample_5, out_sample_4,
                        out_sample_3, out_sample_2, out_sample_1, out_sample_0}, out_count);
      if (in_valid && in_ready)
        sb.note_frame({in_source_sample_7, in_source_sample_6, in_source_sample_5,
                       in_source_sample_4, in_source_sample_3, in_source_sample_2,
                       in_source_sample_1, in_source_sample_0}, in_source_count);
    end
  end

  // Result backpressure: mostly short stalls, a few long ones, some long open stretches
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 50) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 39);
      end else if (ready_roll < 85) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else if (ready_roll < 95) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end else begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(100, 300);
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one frame and hold it until accepted; valid stays high on return
  task automatic send_frame(input lanes_t s, input logic [COUNT_W-1:0] n);
    in_valid           <= 1'b1;
    in_source_sample_0 <= s[0];
    in_source_sample_1 <= s[1];
    in_source_sample_2 <= s[2];
    in_source_sample_3 <= s[3];
    in_source_sample_4 <= s[4];
    in_source_sample_5 <= s[5];
    in_source_sample_6 <= s[6];
    in_source_sample_7 <= s[7];
    in_source_count    <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every outstanding frame has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full register set, written only once the block has gone idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] w_mute, w_gain, w_delay,
                            w_override, w_map_len, w_map_word);
    drain();
    write_reg(REG_MUTE, w_mute);
    write_reg(REG_GAIN, w_gain);
    write_reg(REG_DELAY, w_delay);
    write_reg(REG_OVERRIDE, w_override);
    write_reg(REG_MAP_LEN, w_map_len);
    write_reg(REG_MAP_WORD, w_map_word);
    cfg_valid <= 1'b0;
  endtask

  // Random bits above the field, which the block must ignore
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v, input int w);
    logic [CFG_DATA_W-1:0] m;
    m = (w >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << w) - 1);
    return ($urandom() & ~m) | (v & m);
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned roll, gap, phase_len;
    logic [CFG_DATA_W-1:0] r_mute, r_gain, r_delay, r_override, r_map_len, r_map_word;
    logic [COUNT_W-1:0] base_cnt, cnt;
    bit gappy;
    lanes_t frame;

    sb = new();
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unity gain, no map, no delay; extremes and odd counts
    send_frame({MAX_CHANNELS{24'h7FFFFF}}, 4'd8);
    send_frame({MAX_CHANNELS{24'h800000}}, 4'd8);
    send_frame(MIXED_FRAME, 4'd8);
    send_frame(MIXED_FRAME, 4'd0);
    send_frame(MIXED_FRAME, 4'd15);
    send_frame(MIXED_FRAME, 4'd3);

    // Full-scale gain saturates both ways
    set_config(32'd0, 32'd65535, 32'd0, 32'd0, 32'd0, 32'd0);
    send_frame({MAX_CHANNELS{24'h7FFFFF}}, 4'd8);
    send_frame({MAX_CHANNELS{24'h800000}}, 4'd8);
    send_frame(MIXED_FRAME, 4'd8);

    // Half gain on odd samples: exact halves round away from zero
    set_config(32'd0, 32'd2048, 32'd0, 32'd0, 32'd0, 32'd0);
    send_frame({24'h000007, 24'hFFFFF9, 24'h000005, 24'hFFFFFB,
                24'h000003, 24'hFFFFFD, 24'h000001, 24'hFFFFFF}, 4'd8);

    // Muted with zero gain
    set_config(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_frame(MIXED_FRAME, 4'd8);

    // Oversized map length, silent entries, sources past the count and past eight
    set_config(32'd0, 32'd4096, 32'd0, 32'd0, 32'd12, 32'hF98730F2);
    send_frame(MIXED_FRAME, 4'd4);
    send_frame(MIXED_FRAME, 4'd8);

    // Oversized override beyond a short map
    set_config(32'd0, 32'd4096, 32'd0, 32'd15, 32'd3, 32'h76543210);
    send_frame(MIXED_FRAME, 4'd2);

    // Short delay with wrap; a write past the register list must not clear it
    set_config(32'd0, 32'd4096, 32'd3, 32'd2, 32'd0, 32'd0);
    for (int k = 0; k < 8; k++) begin
      if (k == 4) begin
        drain();
        write_reg(REG_UNMAPPED, '1);
        cfg_valid <= 1'b0;
      end
      send_frame({MAX_CHANNELS{SAMPLE_BITS'(k * 4097 - 9000)}}, 4'd5);
    end

    // Oversized delay acts as the full depth; tiny gain
    set_config(32'd0, 32'd1, 32'd8191, 32'd0, 32'd0, 32'd0);
    repeat (3) send_frame({MAX_CHANNELS{24'h7FFFFF}}, 4'd8);

    // Random phases: fresh settings, then a run with a mostly steady source count
    while (random_sent < RANDOM_ITEMS) begin
      r_mute = ($urandom_range(0, 9) == 0);
      roll = $urandom_range(0, 99);
      r_gain = (roll < 25) ? 4096 : (roll < 35) ? 65535 : (roll < 45) ? 0 :
               (roll < 70) ? $urandom_range(0, 8191) : $urandom_range(0, 65535);
      roll = $urandom_range(0, 99);
      r_delay = (roll < 40) ? 0 : (roll < 80) ? $urandom_range(1, 16) :
                (roll < 90) ? $urandom_range(17, 300) : (roll < 95) ? DELAY_DEPTH :
                $urandom_range(DELAY_DEPTH + 1, 8191);
      roll = $urandom_range(0, 99);
      r_override = (roll < 40) ? 0 : (roll < 90) ? $urandom_range(1, 8) : $urandom_range(9, 15);
      roll = $urandom_range(0, 99);
      r_map_len = (roll < 50) ? 0 : (roll < 90) ? $urandom_range(1, 8) : $urandom_range(9, 15);
      for (int e = 0; e < MAP_ENTRIES; e++) begin
        roll = $urandom_range(0, 99);
        r_map_word[MAP_W*e +: MAP_W] = MAP_W'((roll < 60) ? $urandom_range(0, 7) :
                                       (roll < 80) ? SILENT_ENTRY : $urandom_range(8, 14));
      end
      set_config(with_junk(r_mute, 1), with_junk(r_gain, GAIN_W),
                 with_junk(r_delay, DLY_FIELD_W), with_junk(r_override, COUNT_W),
                 with_junk(r_map_len, COUNT_W), r_map_word);

      phase_len = $urandom_range(8, 40);
      if (r_delay != 0 && r_delay <= 16) phase_len += 2 * r_delay;
      base_cnt = COUNT_W'($urandom_range(1, 8));
      gappy = ($urandom_range(0, 9) < 7);

      repeat (phase_len) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) begin
            frame[c] = SAMPLE_BITS'($urandom());
          end else if (roll < 85) begin
            case ($urandom_range(0, 3))
              0: frame[c] = 24'h7FFFFF;
              1: frame[c] = 24'h800000;
              2: frame[c] = '0;
              default: frame[c] = '1;
            endcase
          end else begin
            frame[c] = SAMPLE_BITS'($urandom_range(0, 8191) - 4096);
          end
        end
        cnt = ($urandom_range(0, 99) < 85) ? base_cnt : COUNT_W'($urandom_range(0, 15));
        send_frame(frame, cnt);
        random_sent++;

        // sender gaps: mostly none or short, now and then long
        if (gappy) begin
          roll = $urandom_range(0, 99);
          gap = (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/acrd_pkg.sv
sv/acrd_front.sv
sv/acrd_lane.sv
sv/audio_channel_router_delay_top.sv
sv/acrd_props.sv
sim/testbench.sv
